/* rtl/tbs_pkg.sv */
// tbs_pkg: shared types and constants for the barycentric triangle subdivider.
// No dependencies; used by tbs_unit and triangle_barycentric_subdivider.
`default_nettype none

package tbs_pkg;

   // vertex axes x, y, z handled one at a time by the shared unit
   localparam int NUM_AXES        = 3;
   localparam int AXIS_WIDTH      = 2;

   // leaf path layout
   localparam int DIGIT_WIDTH     = 3;
   localparam int PATH_WIDTH      = 18;
   localparam int PATH_DIGITS     = 6;
   localparam int DIGIT_IDX_WIDTH = 3;

   // subdivision depth register
   localparam int DEPTH_WIDTH     = 3;

   typedef logic [DIGIT_WIDTH-1:0] digit_type;

   // sub-triangle selected by a path digit (third vertex is always the centroid)
   localparam digit_type SUB_A_MAB = 3'd0;
   localparam digit_type SUB_MAB_B = 3'd1;
   localparam digit_type SUB_B_MBC = 3'd2;
   localparam digit_type SUB_MBC_C = 3'd3;
   localparam digit_type SUB_C_MCA = 3'd4;
   localparam digit_type SUB_MCA_A = 3'd5;
   localparam digit_type MAX_DIGIT = SUB_MCA_A;

   // response error codes
   localparam logic ERR_OK        = 1'b0;
   localparam logic ERR_BAD_DIGIT = 1'b1;

   // sequencer to unit: one axis of one level
   typedef struct packed {
      logic                  issue;
      logic [AXIS_WIDTH-1:0] axis;
      digit_type             digit;
   } unit_ctl_type;

   // unit to sequencer: result write-back
   typedef struct packed {
      logic                  valid;
      logic [AXIS_WIDTH-1:0] axis;
   } unit_res_type;

endpackage

`default_nettype wire

/* rtl/tbs_unit.sv */
// tbs_unit: shared midpoint / centroid unit, one coordinate axis per request.
// Two steps: sums and sub-triangle select, then exact divide by three.
// Depends on tbs_pkg.
`default_nettype none

module tbs_unit #(
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tbs_pkg::unit_ctl_type         ctl,
   input  wire logic signed [COORD_WIDTH-1:0] a_coord,
   input  wire logic signed [COORD_WIDTH-1:0] b_coord,
   input  wire logic signed [COORD_WIDTH-1:0] c_coord,
   output tbs_pkg::unit_res_type              res,
   output logic signed [COORD_WIDTH-1:0]      new_a,
   output logic signed [COORD_WIDTH-1:0]      new_b,
   output logic signed [COORD_WIDTH-1:0]      centroid
);

   localparam int SUM_W = COORD_WIDTH + 2;
   localparam int ND    = (COORD_WIDTH + 3) / 2;   // base-4 digits of the biased sum
   localparam int QW    = 2 * ND;
   localparam int LG    = $clog2(ND);
   // bias of 3 * 2^(CW-1) makes the sum non-negative and keeps it a multiple of 3 away
   localparam logic [SUM_W-1:0] BIAS = SUM_W'(3) << (COORD_WIDTH - 1);

   // add two residues mod 3
   function automatic logic [1:0] add_mod3(input logic [1:0] x, input logic [1:0] y);
      logic [2:0] s;
      s = {1'b0, x} + {1'b0, y};
      return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
   endfunction

   // quotient digit of (4*r + d) / 3
   function automatic logic [1:0] quot_digit(input logic [1:0] r, input logic [1:0] d);
      logic [1:0] q;
      unique case ({r, d})
         4'b0000, 4'b0001, 4'b0010: q = 2'd0;
         4'b0011, 4'b0100, 4'b0101: q = 2'd1;
         4'b0110, 4'b0111, 4'b1000: q = 2'd2;
         4'b1001, 4'b1010, 4'b1011: q = 2'd3;
         default:                   q = 2'd0;
      endcase
      return q;
   endfunction

   // first step: midpoints, biased three-way sum, sub-triangle select
   logic signed [COORD_WIDTH:0]   sum_ab, sum_bc, sum_ca;
   logic signed [COORD_WIDTH-1:0] mab, mbc, mca, sel_a, sel_b;
   logic [SUM_W-1:0]              sum3, biased;

   always_comb begin
      sum_ab = {a_coord[COORD_WIDTH-1], a_coord} + {b_coord[COORD_WIDTH-1], b_coord};
      sum_bc = {b_coord[COORD_WIDTH-1], b_coord} + {c_coord[COORD_WIDTH-1], c_coord};
      sum_ca = {c_coord[COORD_WIDTH-1], c_coord} + {a_coord[COORD_WIDTH-1], a_coord};
      // arithmetic halving rounds toward minus infinity
      mab    = sum_ab[COORD_WIDTH:1];
      mbc    = sum_bc[COORD_WIDTH:1];
      mca    = sum_ca[COORD_WIDTH:1];
      sum3   = {sum_ab[COORD_WIDTH], sum_ab} + {{2{c_coord[COORD_WIDTH-1]}}, c_coord};
      biased = sum3 + BIAS;
      unique case (ctl.digit)
         tbs_pkg::SUB_A_MAB: begin sel_a = a_coord; sel_b = mab;     end
         tbs_pkg::SUB_MAB_B: begin sel_a = mab;     sel_b = b_coord; end
         tbs_pkg::SUB_B_MBC: begin sel_a = b_coord; sel_b = mbc;     end
         tbs_pkg::SUB_MBC_C: begin sel_a = mbc;     sel_b = c_coord; end
         tbs_pkg::SUB_C_MCA: begin sel_a = c_coord; sel_b = mca;     end
         tbs_pkg::SUB_MCA_A: begin sel_a = mca;     sel_b = a_coord; end
         default:            begin sel_a = a_coord; sel_b = b_coord; end
      endcase
   end

   // stage register
   logic                             s1_valid_ff, s1_valid_in;
   logic [tbs_pkg::AXIS_WIDTH-1:0]   s1_axis_ff;
   logic signed [COORD_WIDTH-1:0]    s1_a_ff, s1_b_ff;
   logic [SUM_W-1:0]                 s1_biased_ff;
   logic                             s1_neg_ff;

   assign s1_valid_in = ctl.issue;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_axis_ff   <= ctl.axis;
      s1_a_ff      <= sel_a;
      s1_b_ff      <= sel_b;
      s1_biased_ff <= biased;
      s1_neg_ff    <= sum3[SUM_W-1];
   end

   // second step: divide by three with a mod-3 prefix over base-4 digits
   logic [QW-1:0]          u_pad;
   logic [QW-1:0]          quo;
   logic [1:0]             pre [LG+1][ND];
   logic [1:0]             r_in;
   logic [1:0]             rem;
   logic [COORD_WIDTH-1:0] quo_trunc;

   always_comb begin
      u_pad = QW'(s1_biased_ff);
      // residue of each digit (4 = 1 mod 3, so digits simply add)
      for (int i = 0; i < ND; i++) begin
         pre[0][i] = (u_pad[2*i +: 2] == 2'd3) ? 2'd0 : u_pad[2*i +: 2];
      end
      // suffix sums from the top digit down
      for (int l = 0; l < LG; l++) begin
         for (int i = 0; i < ND; i++) begin
            if (i + (1 << l) < ND) begin
               pre[l+1][i] = add_mod3(pre[l][i], pre[l][i + (1 << l)]);
            end else begin
               pre[l+1][i] = pre[l][i];
            end
         end
      end
      quo = '0;
      for (int i = 0; i < ND; i++) begin
         r_in = (i == ND - 1) ? 2'd0 : pre[LG][(i == ND - 1) ? i : i + 1];
         quo[2*i +: 2] = quot_digit(r_in, u_pad[2*i +: 2]);
      end
      rem = pre[LG][0];
      // remove the bias, then step toward zero for an inexact negative sum
      quo_trunc = {~quo[COORD_WIDTH-1], quo[COORD_WIDTH-2:0]}
                + COORD_WIDTH'(s1_neg_ff && (rem != 2'd0));
   end

   assign res.valid = s1_valid_ff;
   assign res.axis  = s1_axis_ff;
   assign new_a     = s1_a_ff;
   assign new_b     = s1_b_ff;
   assign centroid  = signed'(quo_trunc);

endmodule

`default_nettype wire

/* rtl/triangle_barycentric_subdivider.sv */
// triangle_barycentric_subdivider: top level, sequencer and response register.
// Depends on tbs_pkg and tbs_unit.
`default_nettype none

// Walks one triangle down its leaf path, one subdivision level after another, and
// returns the leaf triangle. The shared midpoint/centroid unit handles one axis per
// cycle, so a request occupies the block until every axis of every level is done
// (no levels at depth zero, fewer when a digit of 6 or 7 ends the walk); depth is
// min(subdivision_depth, MAX_DEPTH). req_tready is high only between requests. A
// finished response sits in the output register while the next request is taken.
// subdivision_depth is written through the csr channel, which is always ready.
module triangle_barycentric_subdivider #(
   parameter int MAX_DEPTH   = 6,
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request: ax, ay, az, bx, by_coord, bz, cx, cy, cz, leaf_path (lowest first)
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [((9*COORD_WIDTH+tbs_pkg::PATH_WIDTH+7)/8)*8-1:0] req_tdata,
   // response: p0x, p0y, p0z, p1x, p1y, p1z, p2x, p2y, p2z (lowest first)
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [((9*COORD_WIDTH+7)/8)*8-1:0]         rsp_tdata,
   // response: error_code
   output logic [0:0]                                 rsp_tuser,
   // subdivision_depth write
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [tbs_pkg::DEPTH_WIDTH-1:0]       csr_wdata
);

   localparam int RSP_W  = ((9 * COORD_WIDTH + 7) / 8) * 8;
   localparam int LVL_W  = $clog2(MAX_DEPTH + 1);
   localparam int CNT_W  = (LVL_W > tbs_pkg::DEPTH_WIDTH) ? LVL_W : tbs_pkg::DEPTH_WIDTH;
   localparam int NA     = tbs_pkg::NUM_AXES;
   localparam logic [tbs_pkg::AXIS_WIDTH-1:0] AXIS_LAST = tbs_pkg::AXIS_WIDTH'(NA - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type                                state_ff, state_in;
   logic [tbs_pkg::DEPTH_WIDTH-1:0]          depth_ff, depth_in;
   logic signed [COORD_WIDTH-1:0]            va_ff [NA];
   logic signed [COORD_WIDTH-1:0]            vb_ff [NA];
   logic signed [COORD_WIDTH-1:0]            vc_ff [NA];
   logic signed [COORD_WIDTH-1:0]            va_in [NA];
   logic signed [COORD_WIDTH-1:0]            vb_in [NA];
   logic signed [COORD_WIDTH-1:0]            vc_in [NA];
   logic [tbs_pkg::PATH_DIGITS-1:0][tbs_pkg::DIGIT_WIDTH-1:0] path_ff, path_in;
   logic [CNT_W-1:0]                         level_ff, level_in;
   logic [tbs_pkg::AXIS_WIDTH-1:0]           axis_ff, axis_in;
   logic                                     err_ff, err_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]                         rsp_data_ff, rsp_data_in;
   logic                                     rsp_err_ff, rsp_err_in;

   logic [CNT_W-1:0]                         depth_ext, eff_depth, lvl_idx;
   tbs_pkg::digit_type                       digit;
   logic                                     bad_digit;
   logic                                     rsp_load;

   tbs_pkg::unit_ctl_type                    ctl;
   tbs_pkg::unit_res_type                    res;
   logic signed [COORD_WIDTH-1:0]            new_a, new_b, centroid;

   // shared arithmetic unit
   tbs_unit #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_unit (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .a_coord  (va_ff[ctl.axis]),
      .b_coord  (vb_ff[ctl.axis]),
      .c_coord  (vc_ff[ctl.axis]),
      .res      (res),
      .new_a    (new_a),
      .new_b    (new_b),
      .centroid (centroid)
   );

   // effective depth and the digit of the current level
   always_comb begin
      depth_ext = CNT_W'(depth_ff);
      eff_depth = (depth_ext > CNT_W'(MAX_DEPTH)) ? CNT_W'(MAX_DEPTH) : depth_ext;
      lvl_idx   = level_ff - CNT_W'(1);
      digit     = (lvl_idx < CNT_W'(tbs_pkg::PATH_DIGITS))
                ? path_ff[lvl_idx[tbs_pkg::DIGIT_IDX_WIDTH-1:0]] : '0;
      bad_digit = digit > tbs_pkg::MAX_DIGIT;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      path_in      = path_ff;
      level_in     = level_ff;
      axis_in      = axis_ff;
      err_in       = err_ff;
      va_in        = va_ff;
      vb_in        = vb_ff;
      vc_in        = vc_ff;
      rsp_load     = 1'b0;
      ctl.issue    = 1'b0;
      ctl.axis     = axis_ff;
      ctl.digit    = digit;

      // config register
      if (csr_valid) begin
         depth_in = csr_wdata;
      end

      // unit write-back
      if (res.valid) begin
         va_in[res.axis] = new_a;
         vb_in[res.axis] = new_b;
         vc_in[res.axis] = centroid;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               for (int k = 0; k < NA; k++) begin
                  va_in[k] = req_tdata[k*COORD_WIDTH +: COORD_WIDTH];
                  vb_in[k] = req_tdata[(NA+k)*COORD_WIDTH +: COORD_WIDTH];
                  vc_in[k] = req_tdata[(2*NA+k)*COORD_WIDTH +: COORD_WIDTH];
               end
               path_in  = req_tdata[3*NA*COORD_WIDTH +: tbs_pkg::PATH_WIDTH];
               err_in   = tbs_pkg::ERR_OK;
               level_in = eff_depth;
               axis_in  = '0;
               state_in = (eff_depth == '0) ? ST_FINISH : ST_RUN;
            end
         end
         ST_RUN: begin
            if (bad_digit) begin
               err_in   = tbs_pkg::ERR_BAD_DIGIT;
               state_in = ST_FINISH;
            end else begin
               ctl.issue = 1'b1;
               if (axis_ff == AXIS_LAST) begin
                  axis_in = '0;
                  if (level_ff == CNT_W'(1)) begin
                     state_in = ST_DRAIN;
                  end else begin
                     level_in = level_ff - CNT_W'(1);
                  end
               end else begin
                  axis_in = axis_ff + tbs_pkg::AXIS_WIDTH'(1);
               end
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_data_in = rsp_data_ff;
      rsp_err_in  = rsp_err_ff;
      if (rsp_load) begin
         rsp_data_in = '0;
         rsp_err_in  = err_ff;
         if (err_ff == tbs_pkg::ERR_OK) begin
            for (int k = 0; k < NA; k++) begin
               rsp_data_in[k*COORD_WIDTH +: COORD_WIDTH]        = va_ff[k];
               rsp_data_in[(NA+k)*COORD_WIDTH +: COORD_WIDTH]   = vb_ff[k];
               rsp_data_in[(2*NA+k)*COORD_WIDTH +: COORD_WIDTH] = vc_ff[k];
            end
         end
      end
      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         level_ff     <= '0;
         axis_ff      <= '0;
         err_ff       <= tbs_pkg::ERR_OK;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
         level_ff     <= level_in;
         axis_ff      <= axis_in;
         err_ff       <= err_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      va_ff       <= va_in;
      vb_ff       <= vb_in;
      vc_ff       <= vc_in;
      path_ff     <= path_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign req_tready   = (state_ff == ST_IDLE);
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_err_ff;
   assign csr_ready    = 1'b1;

endmodule

`default_nettype wire

/* rtl/tbs_checker.sv */
// tbs_checker: port-level assertions for triangle_barycentric_subdivider.
// Bound to the top level below; no package dependency.
`default_nettype none

module tbs_checker #(
   parameter int COORD_WIDTH = 32
) (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [((9*COORD_WIDTH+7)/8)*8-1:0]  rsp_tdata,
   input wire logic [0:0]                          rsp_tuser
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // a bad path returns an all-zero triangle
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("error response carries nonzero data");

   // busy after taking a request
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // a new response only comes from a request in progress
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("response appeared while idle");

   // reset empties the block
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not empty after reset");

endmodule

bind triangle_barycentric_subdivider tbs_checker #(
   .COORD_WIDTH (COORD_WIDTH)
) u_tbs_checker (.*);

`default_nettype wire
